[rtl/fss_pkg.sv]
// Shared types and constants for the fractal segment substitution block.
// Depends on nothing; every other file of the block but fss_ifs imports it.
package fss_pkg;

	// Fraction bits of the Q16.16 coordinate format
	localparam int FRAC_BITS = 16;

	// APB port geometry: two 32-bit registers at byte addresses 0 and 4
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register index codes (paddr[2])
	localparam logic REG_SHAPE_POINTS = 1'b0;
	localparam logic REG_MIRROR_Y     = 1'b1;

	// Item opcodes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_CURVE = 1'b1;

	// Segment direction codes
	localparam logic [1:0] DIR_PX = 2'd0;
	localparam logic [1:0] DIR_PY = 2'd1;
	localparam logic [1:0] DIR_NX = 2'd2;
	localparam logic [1:0] DIR_NY = 2'd3;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_ABS,
		ST_LEN,
		ST_ISSUE,
		ST_DRAIN
	} fss_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic tbl_wr;    // write the replacement table slot
		logic set_prev;  // store the input point as previous point
		logic take;      // latch the input point as segment end
		logic seg_diff;  // form coordinate differences
		logic seg_abs;   // form absolute differences and direction
		logic seg_len;   // form saturated Manhattan length
		logic issue;     // push one replacement point into the pipeline
		logic last;      // the issued point is the last of this item
		logic commit;    // segment end becomes previous point
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic adv;   // pipeline advances this cycle
		logic busy;  // a point is still in the arithmetic stages
	} dp_stat_t;

endpackage

[rtl/fss_ifs.sv]
// Valid/ready channel interfaces for input items and result items.
// Widths follow the coordinate and table-index parameters of the top level.
interface fss_in_if #(
	parameter int COORD_WIDTH = 32,
	parameter int IDX_W = 4
) ();
	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [IDX_W-1:0]       point_index;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic                   curve_start;
	logic                   curve_end;

	modport source (
		output valid, opcode, point_index, coord_x, coord_y, curve_start, curve_end,
		input ready
	);
	modport sink (
		input valid, opcode, point_index, coord_x, coord_y, curve_start, curve_end,
		output ready
	);
endinterface

interface fss_out_if #(
	parameter int COORD_WIDTH = 32
) ();
	logic                   valid;
	logic                   ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic                   run_last;
	logic                   saturated;

	modport source (
		output valid, out_x, out_y, run_last, saturated,
		input ready
	);
	modport sink (
		input valid, out_x, out_y, run_last, saturated,
		output ready
	);
endinterface

[rtl/fractal_segment_substitution.sv]
// Fractal segment substitution, one deepening pass over an axis-aligned curve.
// Load items (opcode 0) write one replacement point and curve-start items store
// the previous point. A segment item is accepted, passes the setup states for
// difference, magnitude and length, then issues its replacement points (as many
// as the shape points, or one fewer when the item does not end the curve) one
// per cycle while the pipeline advances, from the single read port of the
// replacement table, then waits for the last point to pass the arithmetic
// stages. Points leave a seven-stage pipeline that ends in the output register,
// one per cycle while the sink takes them; a stalled sink holds the whole
// pipeline and stretches the item by the stall. After the last point of a
// segment reaches the output register, the controller leaves the drain state
// for idle and only then takes the next input item. Coordinates are signed
// Q16.16; all arithmetic clips and flags it.
// Depends on fss_pkg, fss_ifs, fss_regs, fss_ctrl and fss_dp.
module fractal_segment_substitution #(
	parameter int MAX_SHAPE_POINTS = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fss_in_if.sink                      points,
	fss_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fss_pkg::APB_AW-1:0]  paddr,
	input  logic [fss_pkg::APB_DW-1:0]  pwdata,
	output logic [fss_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import fss_pkg::*;

	localparam int KW    = $clog2(MAX_SHAPE_POINTS + 1);
	localparam int IDX_W = $clog2(MAX_SHAPE_POINTS);

	logic [KW-1:0]    shape_points;
	logic             mirror_y;
	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDX_W-1:0] rd_idx;

	fss_regs #(
		.MAX_SHAPE_POINTS(MAX_SHAPE_POINTS)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.shape_points (shape_points),
		.mirror_y     (mirror_y)
	);

	fss_ctrl #(
		.MAX_SHAPE_POINTS(MAX_SHAPE_POINTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (points.valid),
		.in_ready     (points.ready),
		.opcode       (points.opcode),
		.curve_start  (points.curve_start),
		.curve_end    (points.curve_end),
		.shape_points (shape_points),
		.stat         (stat),
		.cmd          (cmd),
		.rd_idx       (rd_idx)
	);

	fss_dp #(
		.MAX_SHAPE_POINTS(MAX_SHAPE_POINTS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.rd_idx        (rd_idx),
		.mirror_y      (mirror_y),
		.pt_index      (points.point_index),
		.pt_x          (points.coord_x),
		.pt_y          (points.coord_y),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.out_x         (results.out_x),
		.out_y         (results.out_y),
		.out_run_last  (results.run_last),
		.out_saturated (results.saturated)
	);

endmodule

[rtl/fss_regs.sv]
// APB configuration registers: shape point count and y mirror flag.
// Depends on fss_pkg for register codes and port geometry.
module fss_regs #(
	parameter int MAX_SHAPE_POINTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fss_pkg::APB_AW-1:0]  paddr,
	input  logic [fss_pkg::APB_DW-1:0]  pwdata,
	output logic [fss_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [$clog2(MAX_SHAPE_POINTS+1)-1:0] shape_points,
	output logic                        mirror_y
);
	import fss_pkg::*;

	localparam int KW = $clog2(MAX_SHAPE_POINTS + 1);

	logic                  wr_en;
	logic                  reg_sel;
	logic [KW-1:0]         shape_points_q;
	logic                  mirror_y_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[2];

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_points_q <= KW'(2);
			mirror_y_q     <= 1'b0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SHAPE_POINTS: shape_points_q <= pwdata[KW-1:0];
				REG_MIRROR_Y:     mirror_y_q     <= pwdata[0];
				default:          mirror_y_q     <= mirror_y_q;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_SHAPE_POINTS: prdata = APB_DW'(shape_points_q);
			REG_MIRROR_Y:     prdata = APB_DW'(mirror_y_q);
			default:          prdata = '0;
		endcase
	end

	assign shape_points = shape_points_q;
	assign mirror_y     = mirror_y_q;

endmodule

[rtl/fss_ctrl.sv]
// Controller: decodes input items, sequences segment setup and issues
// replacement points into the datapath. Depends on fss_pkg.
module fss_ctrl #(
	parameter int MAX_SHAPE_POINTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic                  curve_start,
	input  logic                  curve_end,
	input  logic [$clog2(MAX_SHAPE_POINTS+1)-1:0] shape_points,
	input  fss_pkg::dp_stat_t     stat,
	output fss_pkg::dp_cmd_t      cmd,
	output logic [$clog2(MAX_SHAPE_POINTS)-1:0] rd_idx
);
	import fss_pkg::*;

	localparam int KW    = $clog2(MAX_SHAPE_POINTS + 1);
	localparam int IDX_W = $clog2(MAX_SHAPE_POINTS);

	fss_state_t    state_q;
	fss_state_t    state_d;
	logic          have_prev_q;
	logic          end_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] last_k_q;

	logic          idle;
	logic          acc;
	logic          start_acc;
	logic          seg_acc;
	logic          k_last;
	logic [KW-1:0] n_pts;

	assign idle      = (state_q == ST_IDLE);
	assign acc       = in_valid & idle;
	assign start_acc = acc & (opcode == OP_CURVE) & (curve_start | ~have_prev_q);
	assign seg_acc   = acc & (opcode == OP_CURVE) & ~curve_start & have_prev_q;
	assign k_last    = (k_q == last_k_q);
	assign rd_idx    = k_q[IDX_W-1:0];

	// Clamp the shape size into the table range
	always_comb begin
		if (shape_points < KW'(2)) begin
			n_pts = KW'(2);
		end else if (shape_points > KW'(MAX_SHAPE_POINTS)) begin
			n_pts = KW'(MAX_SHAPE_POINTS);
		end else begin
			n_pts = shape_points;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (seg_acc) state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_ABS;
			ST_ABS:   state_d = ST_LEN;
			ST_LEN:   state_d = ST_ISSUE;
			ST_ISSUE: if (stat.adv && k_last) state_d = ST_DRAIN;
			ST_DRAIN: if (!stat.busy) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs: ready and datapath commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.tbl_wr   = acc & (opcode == OP_LOAD);
				cmd.set_prev = start_acc;
				cmd.take     = seg_acc;
			end
			ST_DIFF:  cmd.seg_diff = 1'b1;
			ST_ABS:   cmd.seg_abs  = 1'b1;
			ST_LEN:   cmd.seg_len  = 1'b1;
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.last  = k_last;
			end
			ST_DRAIN: cmd.commit = ~stat.busy;
			default:  cmd = '0;
		endcase
	end

	// State register and curve tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			end_q       <= 1'b0;
			k_q         <= '0;
			last_k_q    <= '0;
		end else begin
			state_q <= state_d;
			if (start_acc) begin
				have_prev_q <= 1'b1;
			end else if (cmd.commit && end_q) begin
				have_prev_q <= 1'b0;
			end
			if (seg_acc) begin
				end_q    <= curve_end;
				k_q      <= '0;
				last_k_q <= curve_end ? (n_pts - KW'(1)) : (n_pts - KW'(2));
			end else if (cmd.issue && stat.adv) begin
				k_q <= k_q + KW'(1);
			end
		end
	end

endmodule

[rtl/fss_dp.sv]
// Datapath: replacement table, previous point, segment setup registers and
// the seven-stage point pipeline ending in the output register. Uses fss_pkg.
module fss_dp #(
	parameter int MAX_SHAPE_POINTS = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fss_pkg::dp_cmd_t        cmd,
	output fss_pkg::dp_stat_t       stat,
	input  logic [$clog2(MAX_SHAPE_POINTS)-1:0] rd_idx,
	input  logic                    mirror_y,
	input  logic [$clog2(MAX_SHAPE_POINTS)-1:0] pt_index,
	input  logic [COORD_WIDTH-1:0]  pt_x,
	input  logic [COORD_WIDTH-1:0]  pt_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COORD_WIDTH-1:0]  out_x,
	output logic [COORD_WIDTH-1:0]  out_y,
	output logic                    out_run_last,
	output logic                    out_saturated
);
	import fss_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int IDX_W = $clog2(MAX_SHAPE_POINTS);
	localparam int H     = (CW + 1) / 2;
	localparam int PW    = 4 * H;
	localparam int QW    = PW - FRAC_BITS;
	localparam logic [CW-1:0] VMAX    = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] VMIN    = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] VMIN_P1 = VMIN | CW'(1);
	localparam logic [QW-1:0] Q_HALF  = QW'(1) << (CW - 1);

	// Saturating negate
	function automatic logic [CW-1:0] neg_sat(input logic [CW-1:0] a);
		logic [CW-1:0] r;
		r = (a == VMIN) ? VMAX : (CW'(0) - a);
		return r;
	endfunction

	// Apply the sign to a magnitude product, drop the fraction bits with floor
	// rounding of the signed value and clip; returns {clipped, value}
	function automatic logic [CW:0] scale_fix(input logic [PW-1:0] prod, input logic neg);
		logic [QW-1:0] q;
		logic          inc;
		logic          ovf;
		logic [CW-1:0] val;
		q   = prod[PW-1:FRAC_BITS];
		inc = |prod[FRAC_BITS-1:0];
		if (neg) begin
			ovf = inc ? (q >= Q_HALF) : (q > Q_HALF);
			val = ~q[CW-1:0] + {{(CW-1){1'b0}}, ~inc};
		end else begin
			ovf = (q >= Q_HALF);
			val = q[CW-1:0];
		end
		if (ovf) begin
			val = neg ? VMIN : VMAX;
		end
		return {ovf, val};
	endfunction

	// Saturating add; returns {clipped, value}
	function automatic logic [CW:0] add_sat(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		logic [CW:0] r;
		s = {a[CW-1], a} + {b[CW-1], b};
		if (s[CW] != s[CW-1]) begin
			r = {1'b1, (s[CW] ? VMIN : VMAX)};
		end else begin
			r = {1'b0, s[CW-1:0]};
		end
		return r;
	endfunction

	// Replacement table
	logic [CW-1:0] tbl_x [MAX_SHAPE_POINTS];
	logic [CW-1:0] tbl_y [MAX_SHAPE_POINTS];
	logic          tbl_wr_en;

	// Segment registers
	logic [CW-1:0] prev_x_q, prev_y_q;
	logic [CW-1:0] cur_x_q, cur_y_q;
	logic [CW:0]   dx_q, dy_q;
	logic [CW-1:0] ax_q, ay_q;
	logic [1:0]    dir_q;
	logic [CW-2:0] len_q;
	logic          lensat_q;

	// Pipeline
	logic          adv;
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic          last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic [CW-1:0] tx_s1, ty_s1;
	logic [CW-1:0] rx_s2, ry_s2;
	logic          sat_s2, sat_s3, sat_s4, sat_s5, sat_s6, sat_s7;
	logic [CW-1:0] mx_s3, my_s3;
	logic          nx_s3, ny_s3, nx_s4, ny_s4, nx_s5, ny_s5;
	logic [2*H-1:0] ppx_s4 [4];
	logic [2*H-1:0] ppy_s4 [4];
	logic [PW-1:0] prodx_s5, prody_s5;
	logic [CW-1:0] vx_s6, vy_s6;
	logic [CW-1:0] ox_s7, oy_s7;

	// Segment setup combinational values
	logic [CW:0]   ndx, ndy;
	logic [CW:0]   len_sum;
	logic [1:0]    dir_c;

	// Rotation combinational values
	logic          x_min, y_min;
	logic [CW-1:0] xneg, yneg, ym, ymn;
	logic          ym_sat, ymn_sat;
	logic [CW-1:0] rx_c, ry_c;
	logic          rsat_c;

	// Multiplier operands
	logic [2*H-1:0] mxe, mye, le;

	logic [CW:0]   fx_c, fy_c, tx_c, ty_c;

	assign adv       = ~v_s7 | out_ready;
	assign stat.adv  = adv;
	assign stat.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;
	assign tbl_wr_en = cmd.tbl_wr & ({1'b0, pt_index} < (IDX_W+1)'(MAX_SHAPE_POINTS));

	// Table write on load items, registered read whenever the pipeline advances
	always_ff @(posedge clk) begin
		if (tbl_wr_en) begin
			tbl_x[pt_index] <= pt_x;
			tbl_y[pt_index] <= pt_y;
		end
		if (adv) begin
			tx_s1 <= tbl_x[rd_idx];
			ty_s1 <= tbl_y[rd_idx];
		end
	end

	// Previous point: set on curve start, advance when a segment retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (cmd.set_prev) begin
			prev_x_q <= pt_x;
			prev_y_q <= pt_y;
		end else if (cmd.commit) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
		end
	end

	// Segment setup: difference, magnitude and direction, length
	assign ndx     = (CW+1)'(0) - dx_q;
	assign ndy     = (CW+1)'(0) - dy_q;
	assign len_sum = {1'b0, ax_q} + {1'b0, ay_q};

	always_comb begin
		if (dx_q != '0) begin
			dir_c = dx_q[CW] ? DIR_NX : DIR_PX;
		end else if (dy_q == '0) begin
			dir_c = DIR_NX;
		end else begin
			dir_c = dy_q[CW] ? DIR_NY : DIR_PY;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_x_q <= pt_x;
			cur_y_q <= pt_y;
		end
		if (cmd.seg_diff) begin
			dx_q <= {cur_x_q[CW-1], cur_x_q} - {prev_x_q[CW-1], prev_x_q};
			dy_q <= {cur_y_q[CW-1], cur_y_q} - {prev_y_q[CW-1], prev_y_q};
		end
		if (cmd.seg_abs) begin
			ax_q  <= dx_q[CW] ? ndx[CW-1:0] : dx_q[CW-1:0];
			ay_q  <= dy_q[CW] ? ndy[CW-1:0] : dy_q[CW-1:0];
			dir_q <= dir_c;
		end
		if (cmd.seg_len) begin
			if (len_sum > {1'b0, VMAX}) begin
				len_q    <= VMAX[CW-2:0];
				lensat_q <= 1'b1;
			end else begin
				len_q    <= len_sum[CW-2:0];
				lensat_q <= 1'b0;
			end
		end
	end

	// Mirror and rotate one shape point
	always_comb begin
		x_min   = (tx_s1 == VMIN);
		y_min   = (ty_s1 == VMIN);
		xneg    = neg_sat(tx_s1);
		yneg    = neg_sat(ty_s1);
		ym      = mirror_y ? yneg : ty_s1;
		ym_sat  = mirror_y & y_min;
		ymn     = mirror_y ? (y_min ? VMIN_P1 : ty_s1) : yneg;
		ymn_sat = y_min;
		case (dir_q)
			DIR_PY: begin
				rx_c   = ymn;
				ry_c   = tx_s1;
				rsat_c = ymn_sat;
			end
			DIR_NX: begin
				rx_c   = xneg;
				ry_c   = ymn;
				rsat_c = x_min | ymn_sat;
			end
			DIR_NY: begin
				rx_c   = ym;
				ry_c   = xneg;
				rsat_c = ym_sat | x_min;
			end
			default: begin
				rx_c   = tx_s1;
				ry_c   = ym;
				rsat_c = ym_sat;
			end
		endcase
	end

	assign mxe = (2*H)'(mx_s3);
	assign mye = (2*H)'(my_s3);
	assign le  = (2*H)'(len_q);

	assign fx_c = scale_fix(prodx_s5, nx_s5);
	assign fy_c = scale_fix(prody_s5, ny_s5);
	assign tx_c = add_sat(vx_s6, prev_x_q);
	assign ty_c = add_sat(vy_s6, prev_y_q);

	// Stage valid bits; hold everything while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= cmd.last;

			// rotate
			rx_s2   <= rx_c;
			ry_s2   <= ry_c;
			sat_s2  <= rsat_c | lensat_q;
			last_s2 <= last_s1;

			// magnitude and sign
			nx_s3   <= rx_s2[CW-1];
			ny_s3   <= ry_s2[CW-1];
			mx_s3   <= rx_s2[CW-1] ? (CW'(0) - rx_s2) : rx_s2;
			my_s3   <= ry_s2[CW-1] ? (CW'(0) - ry_s2) : ry_s2;
			sat_s3  <= sat_s2;
			last_s3 <= last_s2;

			// partial products of magnitude times length
			ppx_s4[0] <= (2*H)'(mxe[H-1:0]) * (2*H)'(le[H-1:0]);
			ppx_s4[1] <= (2*H)'(mxe[H-1:0]) * (2*H)'(le[2*H-1:H]);
			ppx_s4[2] <= (2*H)'(mxe[2*H-1:H]) * (2*H)'(le[H-1:0]);
			ppx_s4[3] <= (2*H)'(mxe[2*H-1:H]) * (2*H)'(le[2*H-1:H]);
			ppy_s4[0] <= (2*H)'(mye[H-1:0]) * (2*H)'(le[H-1:0]);
			ppy_s4[1] <= (2*H)'(mye[H-1:0]) * (2*H)'(le[2*H-1:H]);
			ppy_s4[2] <= (2*H)'(mye[2*H-1:H]) * (2*H)'(le[H-1:0]);
			ppy_s4[3] <= (2*H)'(mye[2*H-1:H]) * (2*H)'(le[2*H-1:H]);
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			sat_s4  <= sat_s3;
			last_s4 <= last_s3;

			// combine partial products
			prodx_s5 <= PW'(ppx_s4[0]) + (PW'(ppx_s4[1]) << H)
				+ (PW'(ppx_s4[2]) << H) + (PW'(ppx_s4[3]) << (2*H));
			prody_s5 <= PW'(ppy_s4[0]) + (PW'(ppy_s4[1]) << H)
				+ (PW'(ppy_s4[2]) << H) + (PW'(ppy_s4[3]) << (2*H));
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
			sat_s5  <= sat_s4;
			last_s5 <= last_s4;

			// scale back to Q16.16 and clip
			vx_s6   <= fx_c[CW-1:0];
			vy_s6   <= fy_c[CW-1:0];
			sat_s6  <= sat_s5 | fx_c[CW] | fy_c[CW];
			last_s6 <= last_s5;

			// translate to the previous point into the output register
			ox_s7   <= tx_c[CW-1:0];
			oy_s7   <= ty_c[CW-1:0];
			sat_s7  <= sat_s6 | tx_c[CW] | ty_c[CW];
			last_s7 <= last_s6;
		end
	end

	assign out_valid     = v_s7;
	assign out_x         = ox_s7;
	assign out_y         = oy_s7;
	assign out_run_last  = last_s7;
	assign out_saturated = sat_s7;

endmodule

[test/fractal_segment_substitution_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for fractal_segment_substitution: streams load and curve items,
// expands each segment in a scoreboard class and compares every emitted point.
// Depends on fss_pkg, the fss_in_if/fss_out_if interfaces and the block's RTL.
module fractal_segment_substitution_test;
	import fss_pkg::*;

	localparam int COORD_W = 32;
	localparam int SHAPE_MAX = 16;
	localparam int WATCHDOG_LIMIT = 2500;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 38;
	localparam int NUM_PHASES = 8;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh00010000;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct {
		logic opcode;
		logic [3:0] point_index;
		coord_t coord_x;
		coord_t coord_y;
		logic curve_start;
		logic curve_end;
	} curve_item_t;

	typedef struct {
		coord_t out_x;
		coord_t out_y;
		logic run_last;
		logic saturated;
	} curve_point_t;

	// Expands curve segments into the expected replacement points
	class substitution_scoreboard;
		coord_t shape_x[SHAPE_MAX];
		coord_t shape_y[SHAPE_MAX];
		coord_t prev_x;
		coord_t prev_y;
		bit have_prev;
		logic [4:0] shape_points;
		logic mirror_y;
		curve_point_t expected_points[$];
		int errors;

		function new();
			foreach (shape_x[k]) begin
				shape_x[k] = '0;
				shape_y[k] = '0;
			end
			prev_x = '0;
			prev_y = '0;
			have_prev = 1'b0;
			shape_points = 5'd2;
			mirror_y = 1'b0;
			errors = 0;
		endfunction

		function void set_register(logic index, logic [31:0] value);
			if (index == REG_SHAPE_POINTS) shape_points = value[4:0];
			else mirror_y = value[0];
		endfunction

		function longint clip(longint v, inout bit sat);
			if (v > Q_MAX) begin
				sat = 1'b1;
				return Q_MAX;
			end
			if (v < Q_MIN) begin
				sat = 1'b1;
				return Q_MIN;
			end
			return v;
		endfunction

		// Q16.16 product, floored, then clipped
		function longint scale(longint a, longint len, inout bit sat);
			return clip((a * len) >>> FRAC_BITS, sat);
		endfunction

		function void note_item(curve_item_t it);
			longint px, py, cx, cy, dx, dy, len, sx, sy, rx, ry;
			bit len_sat, sat;
			int n, count;
			logic [1:0] dir;
			curve_point_t p;
			if (it.opcode == OP_LOAD) begin
				shape_x[it.point_index] = it.coord_x;
				shape_y[it.point_index] = it.coord_y;
				return;
			end
			// a start flag or a missing previous point only anchors the curve
			if (it.curve_start || !have_prev) begin
				prev_x = it.coord_x;
				prev_y = it.coord_y;
				have_prev = 1'b1;
				return;
			end
			n = int'(shape_points);
			if (n < 2) n = 2;
			if (n > SHAPE_MAX) n = SHAPE_MAX;
			px = prev_x;
			py = prev_y;
			cx = it.coord_x;
			cy = it.coord_y;
			if (cx != px) dir = (cx > px) ? DIR_PX : DIR_NX;
			else if (cy > py) dir = DIR_PY;
			else if (cy < py) dir = DIR_NY;
			else dir = DIR_NX;
			dx = cx - px;
			dy = cy - py;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			len_sat = 1'b0;
			len = clip(dx + dy, len_sat);
			// drop the closing shape point unless the curve ends here
			count = it.curve_end ? n : n - 1;
			for (int k = 0; k < count; k++) begin
				sat = len_sat;
				sx = shape_x[k];
				sy = shape_y[k];
				if (mirror_y) sy = clip(-sy, sat);
				case (dir)
					DIR_PY: begin
						rx = clip(-sy, sat);
						ry = sx;
					end
					DIR_NX: begin
						rx = clip(-sx, sat);
						ry = clip(-sy, sat);
					end
					DIR_NY: begin
						rx = sy;
						ry = clip(-sx, sat);
					end
					default: begin
						rx = sx;
						ry = sy;
					end
				endcase
				rx = clip(scale(rx, len, sat) + px, sat);
				ry = clip(scale(ry, len, sat) + py, sat);
				p.out_x = rx[COORD_W-1:0];
				p.out_y = ry[COORD_W-1:0];
				p.run_last = (k == count - 1);
				p.saturated = sat;
				expected_points.push_back(p);
			end
			prev_x = it.coord_x;
			prev_y = it.coord_y;
			if (it.curve_end) have_prev = 1'b0;
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_point(curve_point_t got);
			curve_point_t want;
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected point: actual x=%h y=%h", $time, got.out_x, got.out_y);
				errors++;
				return;
			end
			want = expected_points.pop_front();
			compare("out_x", want.out_x, got.out_x);
			compare("out_y", want.out_y, got.out_y);
			compare("run_last", 32'(want.run_last), 32'(got.run_last));
			compare("saturated", 32'(want.saturated), 32'(got.saturated));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	fss_in_if #(.COORD_WIDTH(COORD_W), .IDX_W(4)) points_ch ();
	fss_out_if #(.COORD_WIDTH(COORD_W)) results_ch ();

	substitution_scoreboard sb;
	bit calm;
	int send_idle_pct;
	int items_sent;
	int results_seen;
	int quiet_cycles;

	fractal_segment_substitution #(
		.MAX_SHAPE_POINTS(SHAPE_MAX),
		.COORD_WIDTH(COORD_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points_ch),
		.results(results_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic coord_t any_coord();
		case ($urandom_range(0, 4))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return '0;
			default: return $urandom();
		endcase
	endfunction

	// mostly within +-2.0, now and then anything
	function automatic coord_t shape_coord();
		if ($urandom_range(0, 7) == 0) return any_coord();
		return int'($urandom_range(0, 262144)) - 131072;
	endfunction

	function automatic int step_len();
		if ($urandom_range(0, 9) == 0) return 0;
		return int'($urandom_range(0, 524288)) - 262144;
	endfunction

	function automatic curve_item_t mk_load(int slot, coord_t x, coord_t y);
		curve_item_t it;
		it.opcode = OP_LOAD;
		it.point_index = slot[3:0];
		it.coord_x = x;
		it.coord_y = y;
		it.curve_start = 1'($urandom_range(0, 1));
		it.curve_end = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic curve_item_t mk_point(coord_t x, coord_t y, bit first, bit closing);
		curve_item_t it;
		it.opcode = OP_CURVE;
		it.point_index = 4'($urandom_range(0, 15));
		it.coord_x = x;
		it.coord_y = y;
		it.curve_start = first;
		it.curve_end = closing;
		return it;
	endfunction

	// Offer one item after an optional gap; return at the falling edge after acceptance
	task automatic send_item(input curve_item_t it);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 14);
		if (gap > 0) begin
			points_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		points_ch.opcode = it.opcode;
		points_ch.point_index = it.point_index;
		points_ch.coord_x = it.coord_x;
		points_ch.coord_y = it.coord_y;
		points_ch.curve_start = it.curve_start;
		points_ch.curve_end = it.curve_end;
		points_ch.valid = 1'b1;
		@(posedge clk);
		while (points_ch.ready !== 1'b1) @(posedge clk);
		sb.note_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [4:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {index, 2'b00};
		pwdata = ($urandom() & ~32'h1F) | 32'(value);
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		sb.set_register(index, pwdata);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.expected_points.size() != 0) @(negedge clk);
	endtask

	// Well-formed curve of axis-aligned segments, sometimes left open
	task automatic send_curve();
		coord_t x, y;
		int segs;
		x = int'($urandom_range(0, 33554431)) - 16777216;
		y = int'($urandom_range(0, 33554431)) - 16777216;
		segs = $urandom_range(1, 6);
		send_item(mk_point(x, y, $urandom_range(0, 7) != 0, 1'b0));
		for (int s = 0; s < segs; s++) begin
			if ($urandom_range(0, 2) == 0) x += step_len();
			else y += step_len();
			send_item(mk_point(x, y, 1'b0, s == segs - 1 && $urandom_range(0, 9) != 0));
		end
	endtask

	task automatic run_directed();
		coord_t x, y;
		// fill every slot, extremes first
		for (int k = 0; k < SHAPE_MAX; k++) begin
			case (k)
				0: begin x = '0; y = '0; end
				1: begin x = Q_ONE; y = '0; end
				2: begin x = 32'sh7FFFFFFF; y = 32'sh80000000; end
				3: begin x = 32'sh80000000; y = 32'sh7FFFFFFF; end
				4: begin x = 32'sh00008000; y = -32'sh00008000; end
				5: begin x = -32'sd1; y = 32'sd1; end
				default: begin x = shape_coord(); y = shape_coord(); end
			endcase
			send_item(mk_load(k, x, y));
		end
		// all four directions, a zero-length segment, then the curve end
		send_item(mk_point('0, '0, 1'b1, 1'b0));
		send_item(mk_point(Q_ONE, '0, 1'b0, 1'b0));
		send_item(mk_point(Q_ONE, Q_ONE, 1'b0, 1'b0));
		send_item(mk_point('0, Q_ONE, 1'b0, 1'b0));
		send_item(mk_point('0, '0, 1'b0, 1'b0));
		send_item(mk_point('0, '0, 1'b0, 1'b0));
		send_item(mk_point(2 * Q_ONE, '0, 1'b0, 1'b1));
		// start wins over end; then a full-range segment with a clipped length
		send_item(mk_point(32'sd5, 32'sd5, 1'b1, 1'b1));
		send_item(mk_point(32'sh80000000, 32'sh80000000, 1'b0, 1'b0));
		send_item(mk_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 1'b1));
		// no previous point, then a restart in mid-curve
		send_item(mk_point(32'sd3, 32'sd3, 1'b0, 1'b0));
		send_item(mk_point(32'sd3, 32'sd7, 1'b1, 1'b0));
		send_item(mk_point(32'sd3, Q_ONE + 32'sd3, 1'b0, 1'b1));
	endtask

	// Drive stimulus phase by phase, reconfiguring while the block is idle
	initial begin
		int phase_points[NUM_PHASES];
		bit phase_mirror[NUM_PHASES];
		int phase_start;
		int pick;
		bit paused;
		phase_points = '{16, 2, 5, 0, 31, 1, 17, 9};
		phase_mirror = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		points_ch.valid = 1'b0;
		points_ch.opcode = OP_LOAD;
		points_ch.point_index = '0;
		points_ch.coord_x = '0;
		points_ch.coord_y = '0;
		points_ch.curve_start = 1'b0;
		points_ch.curve_end = 1'b0;
		calm = 1'b0;
		send_idle_pct = 0;
		items_sent = 0;
		paused = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				points_ch.valid = 1'b0;
				wait_drained();
				repeat (SETTLE_CYCLES) @(negedge clk);
			end
			write_reg(REG_SHAPE_POINTS, 5'(phase_points[ph]));
			write_reg(REG_MIRROR_Y, 5'(phase_mirror[ph]));
			calm = (ph == NUM_PHASES - 1);
			case ($urandom_range(0, 2))
				0: send_idle_pct = 0;
				1: send_idle_pct = 8;
				default: send_idle_pct = 35;
			endcase
			if (ph == 0) run_directed();
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				// hold the sender once until every point has come out
				if (ph == 3 && !paused && items_sent - phase_start > 15) begin
					paused = 1'b1;
					points_ch.valid = 1'b0;
					wait_drained();
					@(negedge clk);
				end
				pick = $urandom_range(0, 99);
				if (pick < 12) send_item(mk_load($urandom_range(0, 15), shape_coord(), shape_coord()));
				else if (pick < 22) send_item(mk_point(any_coord(), any_coord(),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
				else send_curve();
			end
		end
		points_ch.valid = 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_points.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Result sink: random stall bursts, one long hold-off, none at the end
	initial begin
		int stall_left;
		int hold_left;
		int idle_pct;
		int cycle;
		bit held;
		results_ch.ready = 1'b0;
		stall_left = 0;
		hold_left = 0;
		idle_pct = 0;
		cycle = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycle++;
			if (cycle % 128 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 6;
					default: idle_pct = 30;
				endcase
			end
			if (!held && results_seen >= 200) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				results_ch.ready = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 13);
				results_ch.ready = 1'b0;
			end else begin
				results_ch.ready = 1'b1;
			end
		end
	end

	// Check each accepted point against the oldest expectation
	always @(posedge clk) begin
		curve_point_t got;
		if (arst_n && results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
			got.out_x = results_ch.out_x;
			got.out_y = results_ch.out_y;
			got.run_last = results_ch.run_last;
			got.saturated = results_ch.saturated;
			sb.check_point(got);
			results_seen++;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || psel === 1'b1
				|| (points_ch.valid === 1'b1 && points_ch.ready === 1'b1)
				|| (results_ch.valid === 1'b1 && results_ch.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
